// ----- src/mwo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mwo_pkg;

    localparam int PHASE_WIDTH     = 32;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int AMP_WIDTH       = 16;
    localparam int OUT_WIDTH       = 16;
    localparam int CFG_WIDTH       = 32;
    localparam int ADDR_WIDTH      = 4;

    localparam int SINE_N = 1 << SINE_TABLE_BITS;

    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    localparam longint unsigned Q28_HALF_PI = 64'd421657428;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_PHASE_STEP  = 2'd0;
    localparam logic [1:0] REG_WAVE_SHAPE  = 2'd1;
    localparam logic [1:0] REG_DEFAULT_AMP = 2'd2;

    localparam logic [1:0] SHAPE_SINE     = 2'd0;
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
    localparam logic [1:0] SHAPE_SAWTOOTH = 2'd2;
    localparam logic [1:0] SHAPE_SQUARE   = 2'd3;

    localparam logic [AMP_WIDTH-1:0] DEFAULT_AMP_RESET = 16'h7FFF;

    typedef logic [SAMPLE_WIDTH-2:0] t_sine_rom [0:SINE_N];

    typedef struct packed {
        logic                           is_sine;
        logic                           neg;
        logic [SINE_TABLE_BITS:0]       idx;
        logic signed [SAMPLE_WIDTH-1:0] wave;
        logic signed [AMP_WIDTH-1:0]    amp;
    } t_item;

    // restoring long division, quotient only
    function automatic longint unsigned udiv_shift_sub(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned quo;
        longint unsigned rem;
        int              b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // quarter-wave sine, Q28 taylor series through x^15 with truncated terms
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom         rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            v;
        longint            fmax;
        int                i;
        int                k;
        fmax = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
        for (i = 0; i <= SINE_N; i++) begin
            x    = (longint'(i) * Q28_HALF_PI) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 28;
            term = x;
            sum  = longint'(x);
            for (k = 1; k <= 7; k++) begin
                term = (term * x2) >> 28;
                term = udiv_shift_sub(term, longint'((2 * k) * (2 * k + 1)));
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum * fmax + (longint'(1) << 27)) >>> 28;
            if (v > fmax) begin
                v = fmax;
            end
            rom[i] = v[SAMPLE_WIDTH-2:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

// ----- src/mwo_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mwo_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mwo_pkg::AMP_WIDTH-1:0] amplitude_in;
    logic                                 amplitude_present;

    modport source (output valid, amplitude_in, amplitude_present, input ready);
    modport sink   (input valid, amplitude_in, amplitude_present, output ready);
endinterface

interface mwo_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mwo_pkg::OUT_WIDTH-1:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface
`default_nettype wire

// ----- src/mwo_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mwo_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    mwo_in_if.sink                           i_in,
    input  wire [mwo_pkg::PHASE_WIDTH-1:0]   i_phase_step,
    input  wire [1:0]                        i_wave_shape,
    input  wire [mwo_pkg::AMP_WIDTH-1:0]     i_default_amplitude,
    output logic                             o_push_valid,
    input  wire                              i_push_ready,
    output mwo_pkg::t_item                   o_push_item,
    output logic [mwo_pkg::PHASE_WIDTH-1:0]  o_phase
);

    localparam int PW  = mwo_pkg::PHASE_WIDTH;
    localparam int SW  = mwo_pkg::SAMPLE_WIDTH;
    localparam int STB = mwo_pkg::SINE_TABLE_BITS;
    localparam int TW  = SW + 2;
    localparam int FS  = 1 << (SW - 1);

    logic [PW-1:0]         r_phase;
    logic [PW-1:0]         n_phase;
    logic                  w_accept;
    logic [SW:0]           w_u;
    logic signed [TW-1:0]  w_u_ext;
    logic signed [TW-1:0]  w_tri;
    logic [1:0]            w_quad;
    logic [STB-1:0]        w_fine;
    logic signed [SW-1:0]  w_wave;

    assign w_accept     = i_in.valid && i_push_ready;
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;
    assign o_phase      = r_phase;

    // the item works on the advanced phase
    assign n_phase = r_phase + i_phase_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
        end
    end

    assign w_u     = n_phase[PW-1 -: SW+1];
    assign w_u_ext = $signed({1'b0, w_u});
    assign w_quad  = n_phase[PW-1 -: 2];
    assign w_fine  = n_phase[PW-3 -: STB];

    always_comb begin
        if (!w_u[SW]) begin
            w_tri = w_u_ext - TW'(FS);
        end else begin
            w_tri = TW'(3 * FS) - w_u_ext;
        end
        // peak of the triangle clips to full scale minus one
        if (w_tri > TW'(FS - 1)) begin
            w_tri = TW'(FS - 1);
        end
    end

    always_comb begin
        unique case (i_wave_shape)
            mwo_pkg::SHAPE_SINE:     w_wave = '0;
            mwo_pkg::SHAPE_TRIANGLE: w_wave = w_tri[SW-1:0];
            mwo_pkg::SHAPE_SAWTOOTH: w_wave = {~n_phase[PW-1], n_phase[PW-2 -: SW-1]};
            mwo_pkg::SHAPE_SQUARE:   w_wave = n_phase[PW-1] ? {1'b1, {(SW-1){1'b0}}}
                                                            : {1'b0, {(SW-1){1'b1}}};
            default:                 w_wave = '0;
        endcase
    end

    always_comb begin
        o_push_item.is_sine = (i_wave_shape == mwo_pkg::SHAPE_SINE);
        o_push_item.neg     = w_quad[1];
        o_push_item.idx     = w_quad[0] ? ((STB+1)'(mwo_pkg::SINE_N) - {1'b0, w_fine})
                                        : {1'b0, w_fine};
        o_push_item.wave    = w_wave;
        o_push_item.amp     = i_in.amplitude_present ? i_in.amplitude_in
                                                     : $signed(i_default_amplitude);
    end

endmodule
`default_nettype wire

// ----- src/mwo_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mwo_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push_valid,
    output logic                 o_push_ready,
    input  wire mwo_pkg::t_item  i_push_item,
    output logic                 o_pop_valid,
    input  wire                  i_pop_ready,
    output mwo_pkg::t_item       o_pop_item
);

    mwo_pkg::t_item r_mem [0:1];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           w_push;
    logic           w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/mwo_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mwo_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_pop_valid,
    output logic                 o_pop_ready,
    input  wire mwo_pkg::t_item  i_item,
    mwo_out_if.source            o_out,
    output logic                 o_busy
);

    localparam int SW = mwo_pkg::SAMPLE_WIDTH;
    localparam int AW = mwo_pkg::AMP_WIDTH;
    localparam int OW = mwo_pkg::OUT_WIDTH;
    localparam int PRW = SW + AW;

    // stage 1: table read
    logic                   r1_valid;
    logic [SW-2:0]          r1_sine;
    logic                   r1_is_sine;
    logic                   r1_neg;
    logic signed [SW-1:0]   r1_wave;
    logic signed [AW-1:0]   r1_amp;
    // stage 2: product
    logic                   r2_valid;
    logic signed [PRW-1:0]  r2_prod;
    // stage 3: output register
    logic                   r3_valid;
    logic signed [OW-1:0]   r3_sample;

    logic                   w_en1;
    logic                   w_en2;
    logic                   w_en3;
    logic signed [SW-1:0]   w_wave;
    logic signed [PRW-1:0]  w_shift;
    logic signed [OW-1:0]   w_sat;

    assign w_en3       = !r3_valid || o_out.ready;
    assign w_en2       = !r2_valid || w_en3;
    assign w_en1       = !r1_valid || w_en2;
    assign o_pop_ready = w_en1;
    assign o_busy      = r1_valid || r2_valid || r3_valid;

    assign o_out.valid  = r3_valid;
    assign o_out.sample = r3_sample;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_sine    <= mwo_pkg::SINE_ROM[i_item.idx];
            r1_is_sine <= i_item.is_sine;
            r1_neg     <= i_item.neg;
            r1_wave    <= i_item.wave;
            r1_amp     <= i_item.amp;
        end
    end

    always_comb begin
        if (r1_is_sine) begin
            w_wave = r1_neg ? -$signed({1'b0, r1_sine}) : $signed({1'b0, r1_sine});
        end else begin
            w_wave = r1_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_prod <= PRW'(w_wave) * PRW'(r1_amp);
        end
    end

    // floor back to Q1.15, then clip
    assign w_shift = r2_prod >>> (SW - 1);

    always_comb begin
        if (w_shift > PRW'(mwo_pkg::OUT_MAX)) begin
            w_sat = OW'(mwo_pkg::OUT_MAX);
        end else if (w_shift < PRW'(mwo_pkg::OUT_MIN)) begin
            w_sat = OW'(mwo_pkg::OUT_MIN);
        end else begin
            w_sat = w_shift[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_sample <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_valid <= i_pop_valid;
            end
            if (w_en2) begin
                r2_valid <= r1_valid;
            end
            if (w_en3) begin
                r3_valid <= r2_valid;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/multi_waveform_oscillator_core.sv -----
// Multi-waveform numerically controlled oscillator.
// Input channel i_in: one beat per sample tick, carrying an optional Q1.15
// amplitude (amplitude_in, used when amplitude_present is set). Each beat
// advances the phase accumulator by phase_step and yields exactly one beat
// on o_out holding the saturated Q1.15 sample for the selected waveform
// (sine, triangle, rising sawtooth or square) scaled by the amplitude.
// Configuration goes through the APB port: phase_step at 0x0, wave_shape
// at 0x4, default_amplitude at 0x8; writes belong in idle periods.
// A taken beat goes through the queue and the table, product and output
// registers before it shows on o_out. Throughput: one beat per cycle while
// o_out is ready; the phase add is the only loop carried between samples.
// A two-entry queue separates the phase/shape front from the table, multiply
// and saturate pipeline, so a stalled receiver fills the output register,
// then the pipeline, then the queue before i_in.ready drops.
// Reset clears the phase, phase_step and wave_shape, sets the default
// amplitude to 0x7fff and empties the queue and pipeline.
`timescale 1ns / 1ps
`default_nettype none
module multi_waveform_oscillator_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [mwo_pkg::ADDR_WIDTH-1:0]    paddr,
    input  wire  [mwo_pkg::CFG_WIDTH-1:0]     pwdata,
    output logic [mwo_pkg::CFG_WIDTH-1:0]     prdata,
    output logic                              pready,
    mwo_in_if.sink                            i_in,
    mwo_out_if.source                         o_out
);

    localparam int PW = mwo_pkg::PHASE_WIDTH;
    localparam int AW = mwo_pkg::AMP_WIDTH;
    localparam int CW = mwo_pkg::CFG_WIDTH;

    logic [CW-1:0]   r_phase_step;
    logic [1:0]      r_wave_shape;
    logic [AW-1:0]   r_default_amp;
    logic            w_cfg_write;
    logic [1:0]      w_reg_idx;
    logic [PW-1:0]   w_step;
    logic [PW-1:0]   w_phase;
    logic            w_push_valid;
    logic            w_push_ready;
    mwo_pkg::t_item  w_push_item;
    logic            w_q_valid;
    logic            w_q_ready;
    mwo_pkg::t_item  w_q_item;
    logic            w_back_busy;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_reg_idx   = paddr[3:2];
    assign w_step      = PW'(r_phase_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= '0;
            r_wave_shape  <= mwo_pkg::SHAPE_SINE;
            r_default_amp <= mwo_pkg::DEFAULT_AMP_RESET;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                mwo_pkg::REG_PHASE_STEP:  r_phase_step  <= pwdata;
                mwo_pkg::REG_WAVE_SHAPE:  r_wave_shape  <= pwdata[1:0];
                mwo_pkg::REG_DEFAULT_AMP: r_default_amp <= pwdata[AW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            mwo_pkg::REG_PHASE_STEP:  prdata = r_phase_step;
            mwo_pkg::REG_WAVE_SHAPE:  prdata = CW'(r_wave_shape);
            mwo_pkg::REG_DEFAULT_AMP: prdata = CW'(r_default_amp);
            default:                  prdata = '0;
        endcase
    end

    mwo_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in                (i_in),
        .i_phase_step        (w_step),
        .i_wave_shape        (r_wave_shape),
        .i_default_amplitude (r_default_amp),
        .o_push_valid        (w_push_valid),
        .i_push_ready        (w_push_ready),
        .o_push_item         (w_push_item),
        .o_phase             (w_phase)
    );

    mwo_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_item  (w_push_item),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_item   (w_q_item)
    );

    mwo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_q_valid),
        .o_pop_ready (w_q_ready),
        .i_item      (w_q_item),
        .o_out       (o_out),
        .o_busy      (w_back_busy)
    );

`ifndef SYNTHESIS
    // a taken beat must be held somewhere downstream on the next cycle
    a_item_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_q_valid || w_back_busy))
        else $error("accepted beat vanished from queue and pipeline");

    // the phase moves by exactly one step per taken beat
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_phase == PW'($past(w_phase) + $past(w_step))))
        else $error("phase accumulator did not advance by phase_step");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
